// File: src/rsrh_pkg.sv
// Shared types, constants and the constant multiply for the record-set rolling hash.
package rsrh_pkg;

   localparam int unsigned HashWidth = 64;

   localparam logic [31:0] RecordBase  = 32'd1000000009;
   localparam logic [31:0] CombineBase = 32'd1000000007;

   localparam logic [1:0] ModeValueOnly = 2'd0;
   localparam logic [1:0] ModeKeyValue  = 2'd1;
   localparam logic [1:0] ModeGrouped   = 2'd2;

   typedef enum logic [2:0] {
      OP_BYTE      = 3'd0,
      OP_END_KEY   = 3'd1,
      OP_END_VALUE = 3'd2,
      OP_END_GROUP = 3'd3,
      OP_FINISH    = 3'd4
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic [31:0] key_length;
   } item_type;

   // Product modulo 2^64 of a 64-bit value and a 32-bit constant, built from
   // a full 32x32 product of the low half and a truncated 32x32 product of
   // the high half.
   function automatic logic [HashWidth-1:0] mul_mod64(input logic [HashWidth-1:0] x,
                                                      input logic [31:0] c);
      logic [63:0] p_lo;
      logic [31:0] p_hi;
      p_lo = {32'd0, x[31:0]} * {32'd0, c};
      p_hi = x[63:32] * c;
      return p_lo + {p_hi, 32'd0};
   endfunction

endpackage

// File: src/record_set_rolling_hash_core.sv
// Top level of the record-set rolling hash: input register, hash unit and result register.
// Throughput: one transaction per cycle, set by the record multiply-add loop, except while a finish waits.
// A finish waits in the input register only while the result register is full and stalled.
// Reset (synchronous, active high) clears all hash state, both valid flags and hash_mode.
module record_set_rolling_hash_core (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_key_length,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value,
   // Configuration port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);
   import rsrh_pkg::*;

   // Configuration register. The user must write it only while the block is idle (the
   // block does not enforce this), so the hash unit may read it directly.
   logic [1:0] hash_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff <= ModeValueOnly;
      end else if (csr_wr_en) begin
         hash_mode_ff <= csr_wr_data;
      end
   end

   // Input register. Every transaction passes on from here without waiting unless it
   // is a finish whose result would overwrite a result that is still waiting.
   logic     stg_valid_ff, stg_valid_in;
   item_type stg_item_ff;
   logic     req_accept;
   logic     stg_advance;
   logic     stg_finish;
   logic     rsp_valid_ff, rsp_valid_in;

   assign stg_finish  = stg_valid_ff && (stg_item_ff.op == OP_FINISH);
   assign stg_advance = stg_valid_ff && !(stg_finish && rsp_valid_ff && rsp_stall);
   assign req_stall   = stg_valid_ff && !stg_advance;
   assign req_accept  = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         stg_valid_in = 1'b1;
      end else if (stg_advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   // The payload is loaded only on acceptance, so it holds while the stage waits.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_item_ff.op         <= op_type'(req_op);
         stg_item_ff.data_byte  <= req_data_byte;
         stg_item_ff.key_length <= req_key_length;
      end
   end

   // Hash state and its update.
   logic [HashWidth-1:0] total_hash;

   rsrh_hash_unit u_hash_unit (
      .clock      (clock),
      .reset      (reset),
      .item_fire  (stg_advance),
      .item       (stg_item_ff),
      .hash_mode  (hash_mode_ff),
      .total_hash (total_hash)
   );

   // Result register. A finish captures the total as it stood before the finish
   // clears it; the register is freed when the downstream side takes it.
   logic [HashWidth-1:0] hash_value_ff;
   logic                 rsp_load;

   assign rsp_load = stg_advance && stg_finish;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         hash_value_ff <= total_hash;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_value_ff;

endmodule

// File: src/rsrh_hash_unit.sv
// Hash state registers and the per-transaction update of record, group and total hashes.
module rsrh_hash_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_fire,
   input  rsrh_pkg::item_type         item,
   input  logic [1:0]                 hash_mode,
   output logic [rsrh_pkg::HashWidth-1:0] total_hash
);
   import rsrh_pkg::*;

   logic [HashWidth-1:0] record_ff, record_in;
   logic [HashWidth-1:0] group_ff, group_in;
   logic [HashWidth-1:0] total_ff, total_in;
   logic [HashWidth-1:0] rec_mul;
   logic [HashWidth-1:0] comb_src;
   logic [HashWidth-1:0] comb_mul;
   logic                 grouped;

   assign grouped  = (hash_mode == ModeGrouped);
   assign rec_mul  = mul_mod64(record_ff, RecordBase);
   // One combine multiplier serves both end value and end group.
   assign comb_src = (item.op == OP_END_GROUP) ? total_ff : record_ff;
   assign comb_mul = mul_mod64(comb_src, CombineBase);

   always_comb begin
      record_in = record_ff;
      group_in  = group_ff;
      total_in  = total_ff;
      unique case (item.op)
         OP_BYTE: begin
            record_in = rec_mul + {56'd0, item.data_byte};
         end
         OP_END_KEY: begin
            if (grouped) begin
               group_in  = record_ff;
               record_in = '0;
            end
         end
         OP_END_VALUE: begin
            if (grouped) begin
               group_in = group_ff ^ record_ff;
            end else if (hash_mode == ModeKeyValue) begin
               total_in = total_ff ^ (comb_mul + {32'd0, item.key_length});
            end else begin
               total_in = total_ff ^ record_ff;
            end
            record_in = '0;
         end
         OP_END_GROUP: begin
            if (grouped) begin
               total_in = comb_mul + group_ff;
               group_in = '0;
            end
         end
         OP_FINISH: begin
            record_in = '0;
            group_in  = '0;
            total_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_ff <= '0;
         group_ff  <= '0;
         total_ff  <= '0;
      end else if (item_fire) begin
         record_ff <= record_in;
         group_ff  <= group_in;
         total_ff  <= total_in;
      end
   end

   assign total_hash = total_ff;

endmodule

// File: src/rsrh_checker.sv
// Port-level checker for the record-set rolling hash core and its bind statement.
module rsrh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash_value
);
   import rsrh_pkg::*;

   logic req_finish_accept;
   assign req_finish_accept = req_valid && !req_stall && (req_op == OP_FINISH);

   // A waiting result holds its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result changed while stalled");

   // The input side is only ever held back by a waiting, stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // A fresh result follows a finish transaction accepted earlier, through the input and result registers.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_finish_accept, 2))
      else $error("result without a preceding finish");

   // Reset leaves both channels empty.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not clear after reset");

endmodule

bind record_set_rolling_hash_core rsrh_checker u_rsrh_checker (.*);
